// ----- rtl/asvg_pkg.sv -----
// Shared constants, sine coefficients and types for the sector vertex generator.
package asvg_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int TRIG_BITS_DEF  = 16;
    localparam int SIN_A = 51472;
    localparam int SIN_B = 21024;
    localparam int SIN_C = 2320;

    // 360 degrees in Q15 is 45 << 18: drop 18 bits, then multiply by ceil(2^36/45)
    localparam int          OPEN_SHIFT  = 18;
    localparam logic [30:0] RECIP_45    = 31'd1527099484;
    localparam int          RECIP_SHIFT = 36;

    localparam logic [2:0] REG_CENTER_X    = 3'd0;
    localparam logic [2:0] REG_CENTER_Y    = 3'd1;
    localparam logic [2:0] REG_RADIUS      = 3'd2;
    localparam logic [2:0] REG_POINT_COUNT = 3'd3;
    localparam logic [2:0] REG_MOUTH_ANGLE = 3'd4;
    localparam logic [2:0] REG_PHASE_RATE  = 3'd5;

    // frame job handed from front to back
    typedef struct packed {
        logic [31:0] start_acc;
        logic [31:0] step;
        logic [8:0]  n;
    } job_t;
endpackage

// ----- rtl/asvg_sin.sv -----
// Pipelined Q1.15 sine approximation, at most one multiply per stage.
module asvg_sin #(
    parameter int TRIG_BITS = asvg_pkg::TRIG_BITS_DEF
) (
    input  logic                 clk,
    input  logic [TRIG_BITS-1:0] angle,
    output logic signed [16:0]   sine
);
    logic [TRIG_BITS-3:0] frac;
    logic [1:0]  q0_next;
    logic [15:0] x_next;
    logic [1:0]  q1_reg, q2_reg, q3_reg, q4_reg;
    logic [15:0] x1_reg, x2x_reg, x3x_reg;
    logic [31:0] x2_reg, x2b_reg;
    logic [31:0] t1_reg, t2_reg;
    logic [31:0] r_reg;
    logic [31:0] p0, p1, p2;
    logic [31:0] rs;
    logic [1:0]  q4_q;

    assign q0_next = angle[TRIG_BITS-1 -: 2];
    assign frac    = angle[TRIG_BITS-3:0];
    always_comb
    begin
        logic [15:0] xf;
        xf = 16'((48'(frac) << 15) >> (TRIG_BITS - 2));
        x_next = q0_next[0] ? 16'(17'd32768 - 17'(xf)) : xf;
    end

    assign p0 = 32'(x1_reg) * 32'(x1_reg);
    assign p1 = (x2_reg * 32'(asvg_pkg::SIN_C)) >> 15;
    assign p2 = (x2b_reg * t1_reg) >> 15;

    always_ff @(posedge clk)
    begin
        x1_reg  <= x_next;
        q1_reg  <= q0_next;
        x2_reg  <= p0 >> 15;
        x2x_reg <= x1_reg;
        q2_reg  <= q1_reg;
        t1_reg  <= 32'(asvg_pkg::SIN_B) - p1;
        x2b_reg <= x2_reg;
        x3x_reg <= x2x_reg;
        q3_reg  <= q2_reg;
        t2_reg  <= 32'(asvg_pkg::SIN_A) - p2;
        q4_reg  <= q3_reg;
        r_reg   <= 32'((64'(x3x_reg) * 64'(t2_reg)) >> 15);
        q4_q    <= q4_reg;
    end
    assign rs   = (r_reg > 32'd32767) ? 32'd32767 : r_reg;
    assign sine = q4_q[1] ? -$signed({1'b0, rs[15:0]}) : $signed({1'b0, rs[15:0]});
endmodule

// ----- rtl/asvg_front.sv -----
// Front: phase, opening, step division; pushes a frame job.
module asvg_front #(
    parameter int MAX_POINTS = asvg_pkg::MAX_POINTS_DEF,
    parameter int TRIG_BITS  = asvg_pkg::TRIG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [31:0]         elapsed_time,
    input  logic [1:0]          mouth_dir,
    input  logic [6:0]          point_count,
    input  logic [7:0]          mouth_angle,
    input  logic [23:0]         phase_rate,
    output logic                job_valid,
    input  logic                job_full,
    output asvg_pkg::job_t      job
);
    localparam int FB = 32 - TRIG_BITS;
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SIN, S_OPEN, S_ODIV, S_SPAN, S_SDIV, S_PUSH
    } st_t;
    st_t st_reg;
    logic [31:0] t_reg;
    logic [1:0]  dir_reg;
    logic [15:0] phase_reg;
    logic [3:0]  cnt_reg;
    logic signed [16:0] s_out;
    logic [15:0] s_mag;
    logic [39:0] num_reg, quo_reg;
    logic [39:0] rem_reg, den_reg;
    logic [5:0]  bit_reg;
    logic [TRIG_BITS:0] open_reg;
    logic        neg_reg;
    logic [8:0]  n_reg;
    logic [31:0] step_reg;
    logic [TRIG_BITS-1:0] start_w;
    logic [8:0]  pcc;
    logic [55:0] prod;
    logic [39:0] rem_sh;
    logic        sub_ok;
    logic [39:0] quo_next;
    logic signed [TRIG_BITS+2:0] span;
    logic        span_neg;
    logic [TRIG_BITS+1:0] span_mag;

    asvg_sin #(.TRIG_BITS(TRIG_BITS)) u_sin (
        .clk(clk), .angle(TRIG_BITS'((48'(phase_reg) << TRIG_BITS) >> 16)), .sine(s_out));

    assign pcc = (point_count < 7'd3) ? 9'd3 :
                 (9'(point_count) > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : 9'(point_count);
    assign prod   = 56'(t_reg) * 56'(phase_rate);
    assign s_mag  = s_out[16] ? 16'(-s_out) : 16'(s_out);
    assign rem_sh = {rem_reg[38:0], num_reg[39]};
    assign sub_ok = (rem_sh >= den_reg);
    assign quo_next = {quo_reg[38:0], sub_ok};
    // span = 2*opening - turn
    assign span = $signed({1'b0, open_reg, 1'b0})
                  - $signed((TRIG_BITS+3)'(1) << TRIG_BITS);
    assign span_neg = span[TRIG_BITS+2];
    assign span_mag = (TRIG_BITS+2)'(span_neg ? -span : span);
    assign stall  = (st_reg != S_IDLE);
    assign start_w = TRIG_BITS'({dir_reg, {(TRIG_BITS-2){1'b0}}} - open_reg[TRIG_BITS-1:0]);
    assign job_valid = (st_reg == S_PUSH);
    assign job.start_acc = 32'(start_w) << FB;
    assign job.step = step_reg;
    assign job.n = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (valid)
                    begin
                        t_reg <= elapsed_time;
                        dir_reg <= mouth_dir;
                        n_reg <= pcc - 9'd1;
                        st_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    phase_reg <= prod[31:16];
                    cnt_reg <= 4'd0;
                    st_reg <= S_SIN;
                end
                S_SIN:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd6)
                        st_reg <= S_OPEN;
                end
                S_OPEN:
                begin
                    // opening = angle*|s|*2^TB / (45*2^18): drop the power of two first
                    num_reg <= 40'(((48'(mouth_angle) * 48'(s_mag)) << TRIG_BITS)
                                   >> asvg_pkg::OPEN_SHIFT);
                    st_reg <= S_ODIV;
                end
                S_ODIV:
                begin
                    // divide by 45 through the reciprocal, exact below 2^30
                    open_reg <= (TRIG_BITS+1)'((64'(num_reg[29:0])
                                * 64'(asvg_pkg::RECIP_45)) >> asvg_pkg::RECIP_SHIFT);
                    st_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    neg_reg <= span_neg;
                    num_reg <= 40'(span_mag) << FB;
                    den_reg <= 40'(n_reg - 9'd1);
                    rem_reg <= '0;
                    bit_reg <= 6'd0;
                    st_reg <= S_SDIV;
                end
                S_SDIV:
                begin
                    // restoring division, one quotient bit per cycle
                    rem_reg <= sub_ok ? rem_sh - den_reg : rem_sh;
                    quo_reg <= quo_next;
                    num_reg <= {num_reg[38:0], 1'b0};
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd39)
                    begin
                        step_reg <= neg_reg ? 32'(-quo_next) : 32'(quo_next);
                        st_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (!job_full)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/asvg_back.sv -----
// Back: job queue and vertex emitter through the sine pipelines.
module asvg_back #(
    parameter int TRIG_BITS  = asvg_pkg::TRIG_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_full,
    input  asvg_pkg::job_t     job,
    input  logic [14:0]        center_x,
    input  logic [14:0]        center_y,
    input  logic [13:0]        radius,
    output logic               valid,
    input  logic               stall,
    output logic [5:0]         point_index,
    output logic signed [16:0] point_x,
    output logic signed [16:0] point_y,
    output logic               last
);
    localparam int FB = 32 - TRIG_BITS;
    localparam int LAT = 6;
    typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_WAIT, B_OUT} st_t;
    st_t st_reg;
    asvg_pkg::job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    logic [31:0] acc_reg, step_reg;
    logic [8:0]  idx_reg;
    logic [3:0]  wt_reg;
    logic signed [16:0] c_s, s_s;
    logic signed [33:0] rx_reg, ry_reg;
    logic pop;

    asvg_sin #(.TRIG_BITS(TRIG_BITS)) u_cos (.clk(clk),
        .angle(TRIG_BITS'(acc_reg[31:FB] + TRIG_BITS'(1 << (TRIG_BITS-2)))), .sine(c_s));
    asvg_sin #(.TRIG_BITS(TRIG_BITS)) u_sn (.clk(clk),
        .angle(acc_reg[31:FB]), .sine(s_s));

    assign job_full = (cnt_reg == 2'd2);
    assign pop = (st_reg == B_IDLE) && (cnt_reg != 2'd0);

    function automatic logic signed [16:0] sat(input logic signed [35:0] v);
        if (v < -36'sd32768) return -17'sd32768;
        if (v > 36'sd65535) return 17'sd65535;
        return v[16:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (job_valid && !job_full)
            q_reg[wp_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            valid <= 1'b0;
        end
        else
        begin
            if (job_valid && !job_full)
                wp_reg <= ~wp_reg;
            cnt_reg <= cnt_reg + 2'(job_valid && !job_full) - 2'(pop);
            unique case (st_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        acc_reg <= q_reg[rp_reg].start_acc;
                        step_reg <= q_reg[rp_reg].step;
                        idx_reg <= q_reg[rp_reg].n;
                        rp_reg <= ~rp_reg;
                        wt_reg <= '0;
                        st_reg <= B_WAIT;
                    end
                end
                B_WAIT:
                begin
                    // sine pipes settle, then the radius multiply, then the output register
                    wt_reg <= wt_reg + 4'd1;
                    if (wt_reg == 4'(LAT))
                    begin
                        rx_reg <= 34'(c_s) * $signed({20'd0, radius});
                        ry_reg <= 34'(s_s) * $signed({20'd0, radius});
                    end
                    if (wt_reg == 4'(LAT + 1))
                    begin
                        point_index <= idx_reg[5:0];
                        point_x <= sat(36'($signed({1'b0, center_x}))
                                   + 36'((rx_reg + 34'sd16384) >>> 15));
                        point_y <= sat(36'($signed({1'b0, center_y}))
                                   - 36'((ry_reg + 34'sd16384) >>> 15));
                        last <= 1'b0;
                        valid <= 1'b1;
                        st_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (!stall)
                    begin
                        if (last)
                        begin
                            valid <= 1'b0;
                            st_reg <= B_IDLE;
                        end
                        else if (idx_reg == 9'd1)
                        begin
                            point_index <= '0;
                            point_x <= $signed({2'b0, center_x});
                            point_y <= $signed({2'b0, center_y});
                            last <= 1'b1;
                        end
                        else
                        begin
                            valid <= 1'b0;
                            acc_reg <= acc_reg + step_reg;
                            idx_reg <= idx_reg - 9'd1;
                            wt_reg <= '0;
                            st_reg <= B_WAIT;
                        end
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overflow");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> point_index == 6'd0) else $error("last not on center");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && stall |=> valid && $stable(point_x)) else $error("result dropped");
endmodule

// ----- rtl/animated_sector_vertex_generator_unit.sv -----
// Top level of the animated sector vertex generator.
// Usage:
//  Input channel (valid/stall): one request = elapsed_time (Q16.16 s) and
//  mouth_dir. Each request yields n-1 arc vertices (n = point_count clamped to
//  3..MAX_POINTS), index n-1 down to 1, then the center vertex, index 0, with last set.
//  Output channel (valid/stall) carries point_index, point_x, point_y, last.
//  Front: phase multiply, pipelined sine, reciprocal divide for the opening
//  and a 40-step bit-serial division for the arc step; it takes a new request
//  only after its job is pushed. A two-entry job queue lets the front take the
//  next request while the back emits; for each arc vertex the back waits for
//  the sine pipes, then the radius multiply, then the output register, and the
//  center vertex follows the last arc vertex. Throughput is set by the back
//  for large point counts.
//  Reset clears all control; configuration registers return to their defaults.
//  A stalled output holds its vertex; when the queue is full the front
//  holds its finished job. The front raises stall on the input while busy.
//  Configure only while idle.
module animated_sector_vertex_generator_unit #(
    parameter int MAX_POINTS = asvg_pkg::MAX_POINTS_DEF,
    parameter int TRIG_BITS  = asvg_pkg::TRIG_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        elapsed_time,
    input  logic [1:0]         mouth_dir,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         point_index,
    output logic signed [16:0] point_x,
    output logic signed [16:0] point_y,
    output logic               last
);
    logic [14:0] cx_reg, cy_reg;
    logic [13:0] r_reg;
    logic [6:0]  pc_reg;
    logic [7:0]  ma_reg;
    logic [23:0] pr_reg;
    logic job_valid, job_full;
    asvg_pkg::job_t job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= 15'd6400;
            cy_reg <= 15'd4800;
            r_reg  <= 14'd2400;
            pc_reg <= 7'd50;
            ma_reg <= 8'd30;
            pr_reg <= 24'd119519;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                asvg_pkg::REG_CENTER_X:    cx_reg <= cfg_data[14:0];
                asvg_pkg::REG_CENTER_Y:    cy_reg <= cfg_data[14:0];
                asvg_pkg::REG_RADIUS:      r_reg  <= cfg_data[13:0];
                asvg_pkg::REG_POINT_COUNT: pc_reg <= cfg_data[6:0];
                asvg_pkg::REG_MOUTH_ANGLE: ma_reg <= cfg_data[7:0];
                asvg_pkg::REG_PHASE_RATE:  pr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    asvg_front #(.MAX_POINTS(MAX_POINTS), .TRIG_BITS(TRIG_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .elapsed_time(elapsed_time), .mouth_dir(mouth_dir), .point_count(pc_reg),
        .mouth_angle(ma_reg), .phase_rate(pr_reg),
        .job_valid(job_valid), .job_full(job_full), .job(job));

    asvg_back #(.TRIG_BITS(TRIG_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_full(job_full), .job(job),
        .center_x(cx_reg), .center_y(cy_reg), .radius(r_reg),
        .valid(out_valid), .stall(out_stall), .point_index(point_index),
        .point_x(point_x), .point_y(point_y), .last(last));
endmodule
